// File: hdl/lapshp_pkg.sv
package lapshp_pkg;

   localparam int MaxWidthDefault = 2048;
   localparam int CfgBits = 12;
   localparam int RowBits = 12;
   localparam int CsrIndexBits = 1;
   localparam int ChanBits = 8;
   localparam int Taps = 9;
   localparam int CentreTap = 4;
   localparam int SumBits = 12;

   localparam logic [CfgBits-1:0] ResetWidth = 12'd640;
   localparam logic [CfgBits-1:0] ResetHeight = 12'd480;

   localparam logic [CsrIndexBits-1:0] RegFrameWidth = 1'b0;
   localparam logic [CsrIndexBits-1:0] RegFrameHeight = 1'b1;

   localparam logic KindPixel = 1'b0;
   localparam logic KindDrain = 1'b1;

   typedef logic [ChanBits-1:0] chan_type;

   localparam chan_type ChanMax = 8'd255;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   localparam int PixelBits = $bits(pixel_type);

   typedef struct packed {
      logic valid;
      logic drain;
      logic result;
      logic interior;
      logic last;
      logic bank;
   } stage_type;

   function automatic chan_type sharpen(input logic [Taps-1:0][ChanBits-1:0] win);
      logic [SumBits-1:0] sum;
      logic [SumBits-1:0] ten;
      logic [SumBits-1:0] diff;
      sum = '0;
      for (int i = 0; i < Taps; i++) begin
         sum = sum + SumBits'(win[i]);
      end
      ten = SumBits'({win[CentreTap], 3'b000}) + SumBits'({win[CentreTap], 1'b0});
      diff = ten - sum;
      if (ten < sum) begin
         sharpen = '0;
      end else if (diff > SumBits'(ChanMax)) begin
         sharpen = ChanMax;
      end else begin
         sharpen = diff[ChanBits-1:0];
      end
   endfunction

endpackage

// File: hdl/laplacian_sharpen_3x3_unit.sv
// 3x3 Laplacian sharpening of a BGR pixel stream in raster order. The unit takes one word per
// clock unless rsp_tready stalls the output; each word is registered in s1_ff and its result in
// the output register; the result for a pixel is caused by the pixel frame_width+1 positions
// later, and after the last pixel of a frame the host sends drain words (tuser high) to push
// out the remaining results, frame_width+1 of them or the whole frame when it is a single row,
// the last of which carries tlast. The rate is set by the two MAX_WIDTH x 24-bit line RAMs, which
// are read and written once per pixel at the same address with no read-modify-write, since the
// rows alternate between them. The line RAMs are not cleared after reset; their contents never
// reach an output before being written in the current frame. Write frame_width and frame_height
// only while the unit is idle; a write restarts the frame.
module laplacian_sharpen_3x3_unit #(
   parameter int MAX_WIDTH = lapshp_pkg::MaxWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lapshp_pkg::PixelBits-1:0]    req_tdata,   // in_blue, in_green, in_red
   input  logic [0:0]                          req_tuser,   // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lapshp_pkg::PixelBits-1:0]    rsp_tdata,   // out_blue, out_green, out_red
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lapshp_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [lapshp_pkg::CfgBits-1:0]      csr_data
);
   import lapshp_pkg::*;

   localparam int ColBits = $clog2(MAX_WIDTH);
   localparam int EffBits = $clog2(MAX_WIDTH + 1);

   logic [CfgBits-1:0] width_ff, width_in;
   logic [CfgBits-1:0] height_ff, height_in;
   logic [ColBits-1:0] icol_ff, icol_in;
   logic [RowBits-1:0] irow_ff, irow_in;
   logic [ColBits-1:0] ocol_ff, ocol_in;
   logic [RowBits-1:0] orow_ff, orow_in;
   stage_type          s1_ff, s1_in;
   pixel_type          px_ff, px_in;
   pixel_type          rd_a_ff, rd_b_ff;
   pixel_type [8:0]    window_ff, window_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pixel_type          rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   pixel_type          line_a [MAX_WIDTH];
   pixel_type          line_b [MAX_WIDTH];

   logic [EffBits-1:0] eff_w;
   logic [EffBits-1:0] w_m1;
   logic [RowBits-1:0] eff_h;
   logic [RowBits-1:0] h_m1;
   logic               accept;
   logic               cfg_write;
   logic               is_drain;
   logic               frame_done;
   logic               pix_take;
   logic               drain_take;
   logic               pix_emit;
   logic               emit;
   logic               interior;
   logic               last;
   logic               s1_go;
   logic [ColBits-1:0] rd_addr;
   pixel_type          up_px;
   pixel_type          mid_px;
   pixel_type          sharp_px;
   logic [Taps-1:0][ChanBits-1:0] win_b, win_g, win_r;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign accept = req_tvalid && req_tready;

   assign eff_w = (width_ff == '0) ? EffBits'(1) :
                  (32'(width_ff) > MAX_WIDTH) ? EffBits'(MAX_WIDTH) : EffBits'(width_ff);
   assign w_m1 = eff_w - EffBits'(1);
   assign eff_h = (height_ff == '0) ? RowBits'(1) : height_ff;
   assign h_m1 = eff_h - RowBits'(1);

   assign is_drain = (req_tuser[0] == KindDrain);
   assign frame_done = (irow_ff >= eff_h);
   assign pix_take = !is_drain && !frame_done;
   assign drain_take = is_drain && frame_done;
   assign pix_emit = pix_take && ((irow_ff >= RowBits'(2)) ||
                                  (irow_ff == RowBits'(1) && icol_ff != '0));
   assign emit = pix_emit || drain_take;
   assign interior = !is_drain && (eff_w >= EffBits'(3)) && (eff_h >= RowBits'(3)) &&
                     (orow_ff >= RowBits'(1)) &&
                     ({1'b0, orow_ff} + (RowBits+1)'(2) <= {1'b0, eff_h}) &&
                     (ocol_ff != '0) &&
                     ({1'b0, EffBits'(ocol_ff)} + (EffBits+1)'(2) <= {1'b0, eff_w});
   assign last = (orow_ff == h_m1) && (EffBits'(ocol_ff) == w_m1);
   assign rd_addr = drain_take ? ocol_ff : icol_ff;

   assign s1_go = s1_ff.valid && (!s1_ff.result || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_ff.valid || s1_go;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      icol_in = icol_ff;
      irow_in = irow_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (accept && pix_take) begin
         if (EffBits'(icol_ff) == w_m1) begin
            icol_in = '0;
            irow_in = irow_ff + RowBits'(1);
         end else begin
            icol_in = icol_ff + ColBits'(1);
         end
      end
      if (accept && emit) begin
         if (last) begin
            icol_in = '0;
            irow_in = '0;
            ocol_in = '0;
            orow_in = '0;
         end else if (EffBits'(ocol_ff) == w_m1) begin
            ocol_in = '0;
            orow_in = orow_ff + RowBits'(1);
         end else begin
            ocol_in = ocol_ff + ColBits'(1);
         end
      end
      if (cfg_write) begin
         case (csr_index)
            RegFrameWidth: width_in = csr_data;
            RegFrameHeight: height_in = csr_data;
            default: ;
         endcase
         icol_in = '0;
         irow_in = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_comb begin
      s1_in = s1_ff;
      px_in = px_ff;
      if (accept) begin
         s1_in.valid = pix_take || drain_take;
         s1_in.drain = is_drain;
         s1_in.result = emit;
         s1_in.interior = interior;
         s1_in.last = last;
         s1_in.bank = is_drain ? orow_ff[0] : irow_ff[0];
         px_in = pixel_type'(req_tdata);
      end else if (s1_go) begin
         s1_in.valid = 1'b0;
      end
   end

   assign up_px = s1_ff.bank ? rd_b_ff : rd_a_ff;
   assign mid_px = s1_ff.bank ? rd_a_ff : rd_b_ff;

   always_comb begin
      window_in = window_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]     = window_ff[r*3+1];
         window_in[r*3 + 1] = window_ff[r*3+2];
      end
      window_in[2] = up_px;
      window_in[5] = mid_px;
      window_in[8] = px_ff;
      for (int i = 0; i < Taps; i++) begin
         win_b[i] = window_in[i].blue;
         win_g[i] = window_in[i].green;
         win_r[i] = window_in[i].red;
      end
      sharp_px.blue = sharpen(win_b);
      sharp_px.green = sharpen(win_g);
      sharp_px.red = sharpen(win_r);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (s1_go && s1_ff.result) begin
         rsp_valid_in = 1'b1;
         rsp_last_in = s1_ff.last;
         if (s1_ff.drain) begin
            rsp_data_in = up_px;
         end else if (s1_ff.interior) begin
            rsp_data_in = sharp_px;
         end else begin
            rsp_data_in = window_in[CentreTap];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ResetWidth;
         height_ff <= ResetHeight;
         icol_ff <= '0;
         irow_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         s1_ff <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff <= '0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         icol_ff <= icol_in;
         irow_ff <= irow_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         s1_ff <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go && !s1_ff.drain) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (accept && pix_take && !irow_ff[0]) begin
         line_a[rd_addr] <= pixel_type'(req_tdata);
      end
      if (accept) begin
         rd_a_ff <= line_a[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pix_take && irow_ff[0]) begin
         line_b[rd_addr] <= pixel_type'(req_tdata);
      end
      if (accept) begin
         rd_b_ff <= line_b[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   a_icol_range: assert property (@(posedge clock) disable iff (reset)
      EffBits'(icol_ff) < eff_w)
      else $error("input column beyond frame width");

   a_ocol_range: assert property (@(posedge clock) disable iff (reset)
      EffBits'(ocol_ff) < eff_w)
      else $error("output column beyond frame width");

   a_irow_range: assert property (@(posedge clock) disable iff (reset)
      irow_ff <= eff_h)
      else $error("input row beyond frame height");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (icol_ff == '0) && (irow_ff == '0) && (ocol_ff == '0) && (orow_ff == '0))
      else $error("register write did not restart the frame");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && s1_ff.result && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("word taken while a result is blocked");

endmodule
